// ===== sv/assert_macros.svh =====
// Assertion macros shared by the path check RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PLC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLC_ASSERT(label, cond, msg)
`define PLC_ASSERT_IMPL(label, ante, cons, msg)
`define PLC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/plc_pkg.sv =====
// Types, codes and defaults for the path limit and collision check.
// No dependencies; every other source file but assert_macros.svh imports this package.
package plc_pkg;

  localparam int MAX_OBSTACLES_DEFAULT = 64;
  localparam int QUEUE_DEPTH_DEFAULT   = 4;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVATURE_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_RADIUS      = 2'd3;

  localparam logic [CFG_W-1:0] SPEED_LIMIT_RESET     = 31'd1638400;
  localparam logic [CFG_W-1:0] ACCEL_LIMIT_RESET     = 31'd393216;
  localparam logic [CFG_W-1:0] CURVATURE_LIMIT_RESET = 31'd655360;
  localparam logic [CFG_W-1:0] HIT_RADIUS_RESET      = 31'd196608;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_POINT = 2'd2;

  localparam logic [2:0] FAIL_NONE      = 3'd0;
  localparam logic [2:0] FAIL_SPEED     = 3'd1;
  localparam logic [2:0] FAIL_ACCEL     = 3'd2;
  localparam logic [2:0] FAIL_CURVATURE = 3'd3;
  localparam logic [2:0] FAIL_COLLISION = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] obstacle_x;
    logic signed [31:0] obstacle_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic signed [31:0] curvature;
    logic               has_position;
    logic               has_curvature;
    logic               last_point;
  } item_t;

  typedef struct packed {
    logic       path_valid;
    logic [2:0] fail_reason;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] speed_limit;
    logic [CFG_W-1:0] accel_limit;
    logic [CFG_W-1:0] curvature_limit;
    logic [CFG_W-1:0] hit_radius;
  } cfg_t;

  typedef struct packed {
    logic speed;
    logic accel;
    logic curvature;
    logic collision;
  } fails_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_POINT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    fails_t             fail;
    logic               has_position;
    logic               last;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_VERDICT
  } back_state_t;

endpackage

// ===== sv/plc_if.sv =====
// Valid/ready channel interfaces for request items and verdict items.
// Depends on plc_pkg for the payload types.
interface plc_item_if;
  import plc_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface plc_result_if;
  import plc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/plc_front.sv =====
// Front end: accepts request items, runs the limit checks, queues commands.
// Depends on plc_pkg and plc_item_if.
module plc_front (
  plc_item_if.sink           item,
  input  plc_pkg::cfg_t      cfg,
  output logic               push_valid,
  input  logic               push_ready,
  output plc_pkg::q_entry_t  push_data
);
  import plc_pkg::*;

  // exact 33-bit magnitude, so -2^31 stays 2^31
  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic [32:0] ext;
    logic [32:0] neg;
    ext = {v[31], v};
    neg = -ext;
    return v[31] ? neg : ext;
  endfunction

  logic known;

  assign item.ready = push_ready;
  assign push_valid = item.valid && known;

  always_comb begin
    push_data              = '0;
    known                  = 1'b1;
    push_data.has_position = item.data.has_position;
    push_data.last         = item.data.last_point;
    unique case (item.data.req_type)
      REQ_CLEAR: begin
        push_data.op = OP_CLEAR;
      end
      REQ_ADD: begin
        push_data.op = OP_ADD;
        push_data.x  = item.data.obstacle_x;
        push_data.y  = item.data.obstacle_y;
      end
      REQ_POINT: begin
        push_data.op             = OP_POINT;
        push_data.x              = item.data.point_x;
        push_data.y              = item.data.point_y;
        push_data.fail.speed     = mag33(item.data.speed) > {2'b00, cfg.speed_limit};
        push_data.fail.accel     = mag33(item.data.accel) > {2'b00, cfg.accel_limit};
        push_data.fail.curvature = item.data.has_curvature &&
                                   (mag33(item.data.curvature) > {2'b00, cfg.curvature_limit});
      end
      default: begin
        // unknown request: taken and dropped
        push_data.op = OP_CLEAR;
        known        = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/plc_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on plc_pkg for the entry type.
module plc_queue #(
  parameter int DEPTH = plc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  plc_pkg::q_entry_t  push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output plc_pkg::q_entry_t  pop_data
);
  import plc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  q_entry_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [OW-1:0]   occ;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (occ != OW'(DEPTH));
  assign pop_valid  = (occ != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        occ <= occ + 1'b1;
      end else if (do_pop && !do_push) begin
        occ <= occ - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/plc_back.sv =====
// Back end: obstacle table, collision scan pipeline, sticky flags, verdict.
// Depends on plc_pkg, plc_result_if and assert_macros.svh.
`include "assert_macros.svh"
module plc_back #(
  parameter int MAX_OBSTACLES = plc_pkg::MAX_OBSTACLES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  plc_pkg::q_entry_t         pop_data,
  input  logic [plc_pkg::CFG_W-1:0] hit_radius,
  plc_result_if.source              result
);
  import plc_pkg::*;

  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  back_state_t state, state_next;

  logic signed [31:0] mem_x [MAX_OBSTACLES];
  logic signed [31:0] mem_y [MAX_OBSTACLES];

  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   k;
  fails_t             flags;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic               cur_last;

  // scan pipeline: table read, distance, squares, compare
  logic               s1_v, s2_v, s3_v;
  logic signed [31:0] rx, ry;
  logic [31:0]        dx, dy;
  logic [63:0]        sq_a, sq_b;
  logic               hit_acc;
  logic [61:0]        r2;

  logic               res_valid;
  result_t            res;
  result_t            verdict;

  logic               popped, is_point, scan_start, add_wr;
  logic               pipe_empty, k_last, out_free;
  logic               issue, drain_done, verdict_load;

  logic signed [32:0] dxs, dys;
  logic [32:0]        dxn, dyn;
  logic [64:0]        dist2;

  assign popped     = pop_valid && pop_ready;
  assign is_point   = (pop_data.op == OP_POINT);
  assign scan_start = popped && is_point && pop_data.has_position && (count != '0);
  assign add_wr     = popped && (pop_data.op == OP_ADD) && (count != CNT_W'(MAX_OBSTACLES));
  assign pipe_empty = !(s1_v || s2_v || s3_v);
  assign k_last     = (CNT_W'(k) == count - CNT_W'(1));
  assign out_free   = !res_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid && is_point) begin
          if (pop_data.has_position && (count != '0)) begin
            state_next = BK_SCAN;
          end else if (pop_data.last) begin
            state_next = BK_VERDICT;
          end
        end
      end
      BK_SCAN: begin
        if (k_last) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (pipe_empty) begin
          state_next = cur_last ? BK_VERDICT : BK_IDLE;
        end
      end
      BK_VERDICT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready    = 1'b0;
    issue        = 1'b0;
    drain_done   = 1'b0;
    verdict_load = 1'b0;
    unique case (state)
      BK_IDLE:    pop_ready    = 1'b1;
      BK_SCAN:    issue        = 1'b1;
      BK_DRAIN:   drain_done   = pipe_empty;
      BK_VERDICT: verdict_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    verdict = '0;
    if (flags.speed) begin
      verdict.fail_reason = FAIL_SPEED;
    end else if (flags.accel) begin
      verdict.fail_reason = FAIL_ACCEL;
    end else if (flags.curvature) begin
      verdict.fail_reason = FAIL_CURVATURE;
    end else if (flags.collision) begin
      verdict.fail_reason = FAIL_COLLISION;
    end else begin
      verdict.fail_reason = FAIL_NONE;
    end
    verdict.path_valid = (verdict.fail_reason == FAIL_NONE);
  end

  always_comb begin
    dxs   = {cur_x[31], cur_x} - {rx[31], rx};
    dys   = {cur_y[31], cur_y} - {ry[31], ry};
    dxn   = -dxs;
    dyn   = -dys;
    dist2 = {1'b0, sq_a} + {1'b0, sq_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      k         <= '0;
      flags     <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      hit_acc   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= issue;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      if (popped && (pop_data.op == OP_CLEAR)) begin
        count <= '0;
      end else if (add_wr) begin
        count <= count + 1'b1;
      end
      if (scan_start) begin
        k <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
      if (scan_start) begin
        hit_acc <= 1'b0;
      end else if (s3_v && (dist2 <= {3'b000, r2})) begin
        hit_acc <= 1'b1;
      end
      if (popped && is_point) begin
        flags <= flags | pop_data.fail;
      end else if (drain_done) begin
        flags.collision <= flags.collision | hit_acc;
      end else if (verdict_load) begin
        flags <= '0;
      end
      if (verdict_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (popped) begin
      cur_x    <= pop_data.x;
      cur_y    <= pop_data.y;
      cur_last <= pop_data.last;
    end
    dx   <= dxs[32] ? dxn[31:0] : dxs[31:0];
    dy   <= dys[32] ? dyn[31:0] : dys[31:0];
    sq_a <= dx * dx;
    sq_b <= dy * dy;
    r2   <= hit_radius * hit_radius;
    if (verdict_load) begin
      res <= verdict;
    end
  end

  // obstacle table
  always_ff @(posedge clk) begin
    if (add_wr) begin
      mem_x[count[IDX_W-1:0]] <= pop_data.x;
      mem_y[count[IDX_W-1:0]] <= pop_data.y;
    end
    if (issue) begin
      rx <= mem_x[k];
      ry <= mem_y[k];
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res;

  `PLC_ASSERT(a_count_range, count <= CNT_W'(MAX_OBSTACLES), "obstacle count above table size")
  `PLC_ASSERT_IMPL(a_scan_in_table, issue, CNT_W'(k) < count, "scan index past filled entries")
  `PLC_ASSERT_IMPL(a_idle_pipe_empty, state == BK_IDLE || state == BK_VERDICT, pipe_empty, "scan pipe busy outside scan")
  `PLC_ASSERT_IMPL(a_verdict_code, res_valid, res.path_valid == (res.fail_reason == FAIL_NONE), "verdict bit and reason disagree")
  `PLC_ASSERT_NEXT(a_flags_cleared, verdict_load, flags == '0, "flags not cleared after verdict")

endmodule

// ===== sv/path_limit_and_collision_check.sv =====
// Top level of the path limit and collision check: config registers and wiring.
// Depends on plc_pkg, plc_if, plc_front, plc_queue and plc_back.
//
//   channel  role    handshake     payload
//   item     sink    valid/ready   plc_pkg::item_t (request)
//   result   source  valid/ready   plc_pkg::result_t (verdict)
//   cfg_*    write   cfg_we        cfg_index selects, cfg_wdata value
//
// Clear and add items take effect when the back end pops them from the queue.
// A path point with a position is checked against all N stored obstacles;
// the scan reads one table entry per cycle.
// Reset: config to defaults, table empty, flags clear; table contents stay.
// The front keeps accepting while the queue has room; a stalled verdict
// holds the back end in its verdict state until taken.
module path_limit_and_collision_check #(
  parameter int MAX_OBSTACLES = plc_pkg::MAX_OBSTACLES_DEFAULT,
  parameter int QUEUE_DEPTH   = plc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  plc_item_if.sink                      item,
  plc_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plc_pkg::CFG_W-1:0]     cfg_wdata
);
  import plc_pkg::*;

  cfg_t     cfg;
  logic     push_valid, push_ready;
  q_entry_t push_data;
  logic     pop_valid, pop_ready;
  q_entry_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit     <= SPEED_LIMIT_RESET;
      cfg.accel_limit     <= ACCEL_LIMIT_RESET;
      cfg.curvature_limit <= CURVATURE_LIMIT_RESET;
      cfg.hit_radius      <= HIT_RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPEED_LIMIT:     cfg.speed_limit     <= cfg_wdata;
        CFG_ACCEL_LIMIT:     cfg.accel_limit     <= cfg_wdata;
        CFG_CURVATURE_LIMIT: cfg.curvature_limit <= cfg_wdata;
        CFG_HIT_RADIUS:      cfg.hit_radius      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  plc_front u_front (
    .item       (item),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  plc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  plc_back #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .hit_radius (cfg.hit_radius),
    .result     (result)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for path_limit_and_collision_check: random and directed request items,
// with verdicts predicted in a scoreboard class and checked as they come out.
// Depends on plc_pkg, plc_if and the RTL of the block.
module tb;
  import plc_pkg::*;

  localparam int MAX_OBST = MAX_OBSTACLES_DEFAULT;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [31:0] MIN32 = 32'h8000_0000;
  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE = 32'd65536;
  localparam logic [31:0] SPD_LIM = {1'b0, SPEED_LIMIT_RESET};
  localparam logic [31:0] ACC_LIM = {1'b0, ACCEL_LIMIT_RESET};
  localparam logic [31:0] CRV_LIM = {1'b0, CURVATURE_LIMIT_RESET};
  localparam logic [31:0] RAD = {1'b0, HIT_RADIUS_RESET};
  localparam int RANDOM_PER_PHASE = 72;
  localparam int SETTLE_CYCLES = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  class verdict_scoreboard;
    cfg_t limits;
    logic signed [32:0] obst_x [MAX_OBST];
    logic signed [32:0] obst_y [MAX_OBST];
    int unsigned obst_count;
    fails_t sticky;
    result_t pending_verdicts [$];
    int unsigned errors;

    function new();
      limits = '{SPEED_LIMIT_RESET, ACCEL_LIMIT_RESET, CURVATURE_LIMIT_RESET,
                 HIT_RADIUS_RESET};
      obst_count = 0;
      sticky = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SPEED_LIMIT: limits.speed_limit = val;
        CFG_ACCEL_LIMIT: limits.accel_limit = val;
        CFG_CURVATURE_LIMIT: limits.curvature_limit = val;
        CFG_HIT_RADIUS: limits.hit_radius = val;
        default: ;
      endcase
    endfunction

    function logic [32:0] abs33(logic signed [32:0] v);
      return v < 0 ? -v : v;
    endfunction

    // exact 65-bit sum: a sum past 64 bits can never be under radius squared
    function bit hits_obstacle(logic signed [31:0] px, logic signed [31:0] py);
      logic [64:0] reach, dx2, dy2;
      logic [32:0] mx, my;
      logic signed [32:0] ex, ey;
      reach = limits.hit_radius * limits.hit_radius;
      ex = px;
      ey = py;
      for (int k = 0; k < obst_count; k++) begin
        mx = abs33(ex - obst_x[k]);
        my = abs33(ey - obst_y[k]);
        dx2 = mx * mx;
        dy2 = my * my;
        if (dx2 + dy2 <= reach) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void absorb_request(item_t it);
      result_t v;
      logic [2:0] reason;
      case (it.req_type)
        REQ_CLEAR: obst_count = 0;
        REQ_ADD: begin
          if (obst_count < MAX_OBST) begin
            obst_x[obst_count] = it.obstacle_x;
            obst_y[obst_count] = it.obstacle_y;
            obst_count++;
          end
        end
        REQ_POINT: begin
          if (abs33(it.speed) > limits.speed_limit) sticky.speed = 1'b1;
          if (abs33(it.accel) > limits.accel_limit) sticky.accel = 1'b1;
          if (it.has_curvature && abs33(it.curvature) > limits.curvature_limit)
            sticky.curvature = 1'b1;
          if (it.has_position && hits_obstacle(it.point_x, it.point_y))
            sticky.collision = 1'b1;
          if (it.last_point) begin
            if (sticky.speed) reason = FAIL_SPEED;
            else if (sticky.accel) reason = FAIL_ACCEL;
            else if (sticky.curvature) reason = FAIL_CURVATURE;
            else if (sticky.collision) reason = FAIL_COLLISION;
            else reason = FAIL_NONE;
            v.path_valid = (reason == FAIL_NONE);
            v.fail_reason = reason;
            pending_verdicts = {pending_verdicts, v};
            sticky = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict: path_valid %0d fail_reason %0d",
               got.path_valid, got.fail_reason);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.path_valid !== want.path_valid) begin
        $error("path_valid: expected %0d, actual %0d", want.path_valid, got.path_valid);
        errors++;
      end
      if (got.fail_reason !== want.fail_reason) begin
        $error("fail_reason: expected %0d, actual %0d", want.fail_reason, got.fail_reason);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  plc_item_if item_ch();
  plc_result_if result_ch();

  path_limit_and_collision_check u_top (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  verdict_scoreboard sb = new();
  cfg_t cur_limits = '{SPEED_LIMIT_RESET, ACCEL_LIMIT_RESET, CURVATURE_LIMIT_RESET,
                       HIT_RADIUS_RESET};
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  logic [31:0] placed_x [$];
  logic [31:0] placed_y [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) sb.absorb_request(item_ch.data);
    if (!rst && result_ch.valid && result_ch.ready) sb.check_verdict(result_ch.data);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // verdict side: random stalls, one long hold-off on request, none when calm
  initial begin
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic item_t scrambled(input logic [1:0] req);
    item_t it;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.req_type = req;
    return it;
  endfunction

  function automatic item_t path_point(input logic [31:0] spd, acc, crv, input logic use_crv,
                                       input logic [31:0] px, py, input logic use_pos, last);
    item_t it;
    it = scrambled(REQ_POINT);
    it.speed = spd;
    it.accel = acc;
    it.curvature = crv;
    it.has_curvature = use_crv;
    it.point_x = px;
    it.point_y = py;
    it.has_position = use_pos;
    it.last_point = last;
    return it;
  endfunction

  function automatic item_t obstacle(input logic [31:0] x, y);
    item_t it;
    it = scrambled(REQ_ADD);
    it.obstacle_x = x;
    it.obstacle_y = y;
    return it;
  endfunction

  function automatic logic [31:0] scatter(input logic [31:0] base, input longint spread);
    logic [31:0] m;
    if (spread > longint'(32'hFFFF_FFFF)) spread = longint'(32'hFFFF_FFFF);
    m = $urandom_range(0, spread[31:0]);
    return $urandom_range(0, 1) ? base - m : base + m;
  endfunction

  // value on or just past a limit, within it, or anything at all
  function automatic logic [31:0] around(input logic [CFG_W-1:0] lim);
    logic [31:0] m;
    m = {1'b0, lim};
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return m;
      2: return m + 32'd1;
      3: return -m;
      4: return -m - 32'd1;
      5: return MIN32;
      default: return scatter(32'd0, longint'(m));
    endcase
  endfunction

  task automatic push_item(input item_t it);
    item_ch.data <= it;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    if (it.req_type != REQ_UNKNOWN) items_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // wait for every verdict, then let queued non-verdict work finish
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_limits(input cfg_t c);
    logic [CFG_IDX_W-1:0] slot [4];
    logic [CFG_W-1:0] val [4];
    slot = '{CFG_SPEED_LIMIT, CFG_ACCEL_LIMIT, CFG_CURVATURE_LIMIT, CFG_HIT_RADIUS};
    val = '{c.speed_limit, c.accel_limit, c.curvature_limit, c.hit_radius};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= slot[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(slot[i], val[i]);
    end
    cfg_we <= 1'b0;
    cur_limits = c;
  endtask

  task automatic run_directed();
    item_t it;
    push_item(scrambled(REQ_CLEAR));
    push_item(path_point(0, 0, 0, 1, 0, 0, 1, 1));
    push_item(path_point(SPD_LIM, -ACC_LIM, -CRV_LIM, 1, 0, 0, 1, 1));
    push_item(path_point(SPD_LIM + 1, 0, 0, 0, 0, 0, 0, 1));
    push_item(path_point(MIN32, 0, 0, 0, 0, 0, 0, 1));
    push_item(path_point(0, -ACC_LIM - 1, 0, 0, 0, 0, 0, 1));
    push_item(path_point(0, 0, CRV_LIM + 1, 0, 0, 0, 0, 1));
    push_item(path_point(0, 0, -CRV_LIM - 1, 1, 0, 0, 0, 1));
    push_item(path_point(MAX32, MIN32, MIN32, 1, 0, 0, 0, 1));
    push_item(path_point(0, ACC_LIM + 1, CRV_LIM + 1, 1, 0, 0, 0, 1));
    push_item(obstacle(0, 0));
    push_item(obstacle(MIN32, MIN32));
    it = obstacle(1000 * Q_ONE, 1000 * Q_ONE);
    it.last_point = 1'b1;
    push_item(it);
    // on the radius counts as a hit, one step past it does not
    push_item(path_point(0, 0, 0, 0, RAD, 0, 1, 1));
    push_item(path_point(0, 0, 0, 0, RAD, 1, 1, 1));
    push_item(path_point(0, 0, 0, 0, 0, 0, 0, 1));
    push_item(obstacle(5 * Q_ONE, 5 * Q_ONE));
    push_item(path_point(0, 0, CRV_LIM + 1, 1, 5 * Q_ONE, 5 * Q_ONE, 1, 1));
    it = scrambled(REQ_UNKNOWN);
    it.last_point = 1'b1;
    push_item(it);
    // flags are sticky across points and across a table clear
    push_item(path_point(SPD_LIM + 1, 0, 0, 0, 0, 0, 0, 0));
    push_item(scrambled(REQ_CLEAR));
    push_item(path_point(0, 0, 0, 0, 0, 0, 1, 1));
    push_item(path_point(0, 0, 0, 0, 0, 0, 1, 1));
  endtask

  // with the widest radius, sums near and past 64 bits
  task automatic wide_radius_checks();
    push_item(scrambled(REQ_CLEAR));
    push_item(obstacle(MIN32, MIN32));
    push_item(path_point(0, 0, 0, 1, MAX32, MAX32, 1, 1));
    push_item(path_point(0, 0, 0, 1, MAX32, MIN32, 1, 1));
    push_item(path_point(0, 0, 0, 1, 32'hFFFF_FFFF, MIN32, 1, 1));
    push_item(path_point(MAX32, -MAX32, MIN32, 1, 0, 0, 0, 1));
    push_item(path_point(MIN32, 0, 0, 0, 0, 0, 0, 1));
    placed_x.delete();
    placed_y.delete();
  endtask

  task automatic random_group();
    item_t it;
    int unsigned n_obst, n_pts, k;
    logic [31:0] r;
    r = {1'b0, cur_limits.hit_radius};
    if ($urandom_range(0, 7) == 0) begin
      it = scrambled(2'($urandom_range(0, 3)));
      if (it.req_type == REQ_CLEAR) begin
        placed_x.delete();
        placed_y.delete();
      end else if (it.req_type == REQ_ADD && placed_x.size() < MAX_OBST) begin
        placed_x = {placed_x, it.obstacle_x};
        placed_y = {placed_y, it.obstacle_y};
      end
      push_item(it);
      return;
    end
    if (placed_x.size() == 0 || $urandom_range(0, 2) != 0) begin
      push_item(scrambled(REQ_CLEAR));
      placed_x.delete();
      placed_y.delete();
    end
    // now and then overfill the table
    n_obst = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
    repeat (n_obst) begin
      it = scrambled(REQ_ADD);
      if ($urandom_range(0, 3) != 0) begin
        it.obstacle_x = scatter(0, 3 * longint'(r) + 1);
        it.obstacle_y = scatter(0, 3 * longint'(r) + 1);
      end
      if (placed_x.size() < MAX_OBST) begin
        placed_x = {placed_x, it.obstacle_x};
        placed_y = {placed_y, it.obstacle_y};
      end
      push_item(it);
    end
    n_pts = $urandom_range(1, 5);
    for (int i = 0; i < n_pts; i++) begin
      it = scrambled(REQ_POINT);
      it.speed = ($urandom_range(0, 2) == 0) ? around(cur_limits.speed_limit)
                 : scatter(0, longint'(cur_limits.speed_limit));
      it.accel = ($urandom_range(0, 2) == 0) ? around(cur_limits.accel_limit)
                 : scatter(0, longint'(cur_limits.accel_limit));
      it.curvature = ($urandom_range(0, 2) == 0) ? around(cur_limits.curvature_limit)
                     : scatter(0, longint'(cur_limits.curvature_limit));
      if (placed_x.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, placed_x.size() - 1);
        if ($urandom_range(0, 9) == 0) begin
          it.point_x = placed_x[k] + r;
          it.point_y = placed_y[k];
        end else begin
          it.point_x = scatter(placed_x[k], longint'(r) + (r >> 2) + 1);
          it.point_y = scatter(placed_y[k], longint'(r) + (r >> 2) + 1);
        end
      end
      // a path now and then never gets its last point
      it.last_point = (i == n_pts - 1) && ($urandom_range(0, 11) != 0);
      push_item(it);
    end
  endtask

  initial begin
    cfg_t plan;
    int unsigned quota;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SPEED_LIMIT;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    quota = items_sent;
    for (int ph = 1; ph <= 6; ph++) begin
      settle();
      case (ph)
        1: plan = '0;
        2: plan = '1;
        4: plan = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom)};
        6: plan = '{SPEED_LIMIT_RESET, ACCEL_LIMIT_RESET, CURVATURE_LIMIT_RESET,
                    HIT_RADIUS_RESET};
        default: plan = '{CFG_W'($urandom_range(Q_ONE, 40 * Q_ONE)),
                          CFG_W'($urandom_range(Q_ONE, 10 * Q_ONE)),
                          CFG_W'($urandom_range(Q_ONE, 16 * Q_ONE)),
                          CFG_W'($urandom_range(0, 6 * Q_ONE))};
      endcase
      load_limits(plan);
      if (ph == 2) wide_radius_checks();
      calm = (ph == 6);
      quota += RANDOM_PER_PHASE;
      while (items_sent < quota) begin
        if (ph == 3 && !hold_request && items_sent + 36 >= quota) hold_request = 1'b1;
        random_group();
      end
    end
    settle();
    if (sb.pending_verdicts.size() != 0)
      $error("%0d verdicts never arrived", sb.pending_verdicts.size());
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/plc_pkg.sv
sv/plc_if.sv
sv/plc_front.sv
sv/plc_queue.sv
sv/plc_back.sv
sv/path_limit_and_collision_check.sv
test/tb.sv
